>>> hdl/wsru_pkg.sv
// Package for the word shift and rotate unit: operation codes and stage types.
package wsru_pkg;

	localparam int unsigned OpWidth    = 4;
	localparam int unsigned WordWidth  = 16;
	localparam int unsigned CountWidth = 8;
	localparam int unsigned AmtWidth   = 5;
	localparam logic [AmtWidth-1:0] RcModulus = 5'd17;
	localparam logic [AmtWidth-1:0] HalfShift = 5'd16;

	typedef enum logic [OpWidth-1:0] {
		OP_SHLD = 4'd0,
		OP_SHRD = 4'd1,
		OP_ROL  = 4'd2,
		OP_ROR  = 4'd3,
		OP_RCL  = 4'd4,
		OP_RCR  = 4'd5,
		OP_SHL  = 4'd6,
		OP_SHR  = 4'd7,
		OP_SAR  = 4'd8
	} op_t;

	typedef struct packed {
		logic rv;
		logic cov;
		logic szp;
	} upd_t;

	typedef struct packed {
		logic [OpWidth-1:0]   op;
		logic [WordWidth-1:0] a;
		logic [WordWidth-1:0] b;
		logic                 cin;
		logic [AmtWidth-1:0]  c5;
		logic [3:0]           c4;
		logic [AmtWidth-1:0]  n17;
		upd_t                 upd;
	} dec_t;

	typedef struct packed {
		logic [WordWidth-1:0] res;
		logic                 rv;
		logic                 cf;
		logic                 of;
		logic                 cov;
		logic                 szp;
	} exe_t;

endpackage

>>> hdl/word_shift_rotate_unit.sv
// Word shift and rotate unit: three-stage pipeline for 16-bit x86 shifts and rotates.
//
// Usage:
//   Request channel (req_valid / req_stall) carries op, operand, fill_operand,
//   shift_count and carry_in. An item is taken on a rising edge with req_valid
//   high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) carries the result word, the
//   carry, overflow, sign, zero and parity flags and their write enables.
//   An accepted item passes the stage-one, stage-two and stage-three registers
//   in order; rsp_valid rises once it is in stage three. Stage one decodes
//   and masks the count, stage two runs the barrel shifters, stage three forms
//   the sign, zero and parity flags into the output register.
//   Throughput is one item per cycle while rsp_stall is low; empty stages fill
//   while the output waits, so req_stall rises only once all three stages hold items.
//   When rsp_stall is high the output item holds unchanged until taken.
//   Reset (arst_n low) empties the pipeline; no item is lost or repeated
//   across a stall.
module word_shift_rotate_unit
	import wsru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [OpWidth-1:0]    op,
	input  logic [WordWidth-1:0]  operand,
	input  logic [WordWidth-1:0]  fill_operand,
	input  logic [CountWidth-1:0] shift_count,
	input  logic                  carry_in,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [WordWidth-1:0]  result,
	output logic                  result_valid,
	output logic                  carry_out,
	output logic                  overflow_out,
	output logic                  carry_overflow_valid,
	output logic                  sign_out,
	output logic                  zero_out,
	output logic                  parity_out,
	output logic                  szp_valid
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	dec_t dec_d, dec_s1;
	exe_t exe_d, exe_s2;

	logic [WordWidth-1:0] res_s3;
	logic                 rv_s3, cf_s3, of_s3, cov_s3, sf_s3, zf_s3, pf_s3, szp_s3;

	assign en3       = !v_s3 || !rsp_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_stall = !en1;

	// decode
	logic [AmtWidth-1:0] c5_d;
	logic [3:0]          c4_d;
	logic [AmtWidth-1:0] n17_d;

	always_comb begin
		c5_d  = shift_count[AmtWidth-1:0];
		c4_d  = shift_count[3:0];
		n17_d = (c5_d >= RcModulus) ? c5_d - RcModulus : c5_d;
		dec_d.op  = op;
		dec_d.a   = operand;
		dec_d.b   = fill_operand;
		dec_d.cin = carry_in;
		dec_d.c5  = c5_d;
		dec_d.c4  = c4_d;
		dec_d.n17 = n17_d;
		dec_d.upd = '0;
		unique case (op_t'(op))
			OP_SHLD, OP_SHRD, OP_SHL, OP_SHR, OP_SAR: begin
				dec_d.upd.rv  = c5_d != '0;
				dec_d.upd.cov = c5_d != '0;
				dec_d.upd.szp = c5_d != '0;
			end
			OP_ROL, OP_ROR: begin
				dec_d.upd.rv  = c4_d != '0;
				dec_d.upd.cov = (c4_d != '0) || shift_count[4];
			end
			OP_RCL, OP_RCR: begin
				dec_d.upd.rv  = n17_d != '0;
				dec_d.upd.cov = n17_d != '0;
			end
			default: begin
				dec_d.upd = '0;
			end
		endcase
	end

	// shifters
	logic [AmtWidth-1:0]      sm1;
	logic [2*WordWidth-1:0]   shld_t, shld_x, shrd_r, shrd_x, wide_a, shr_w;
	logic [2*WordWidth-1:0]   rol_w, ror_w, shl_w;
	logic [2*WordWidth+1:0]   rcl_w, rcr_w;
	logic [WordWidth:0]       x17, rcl_y, rcr_y;
	logic [WordWidth-1:0]     shld_res, shrd_res;
	logic signed [WordWidth-1:0] sar_w;
	logic [WordWidth-1:0]     r;
	logic                     c, o;

	always_comb begin
		sm1    = dec_s1.c5 - 5'd1;
		wide_a = {{WordWidth{1'b0}}, dec_s1.a};
		shld_t = {dec_s1.a, dec_s1.b} << sm1;
		shld_x = (dec_s1.c5 > HalfShift) ? wide_a << (dec_s1.c5 - HalfShift) : '0;
		shld_res = shld_t[2*WordWidth-2:WordWidth-1] | shld_x[2*WordWidth-1:WordWidth];
		shrd_r = {dec_s1.b, dec_s1.a} >> dec_s1.c5;
		shrd_x = (dec_s1.c5 > HalfShift) ? wide_a << (5'd0 - dec_s1.c5) : '0;
		shrd_res = shrd_r[WordWidth-1:0] | shrd_x[WordWidth-1:0];
		shr_w  = wide_a >> sm1;
		shl_w  = wide_a << sm1;
		rol_w  = {dec_s1.a, dec_s1.a} << dec_s1.c4;
		ror_w  = {dec_s1.a, dec_s1.a} >> dec_s1.c4;
		x17    = {dec_s1.cin, dec_s1.a};
		rcl_w  = {x17, x17} << dec_s1.n17;
		rcr_w  = {x17, x17} >> dec_s1.n17;
		rcl_y  = rcl_w[2*WordWidth+1:WordWidth+1];
		rcr_y  = rcr_w[WordWidth:0];
		sar_w  = $signed(dec_s1.a) >>> sm1;
		r = dec_s1.a;
		c = 1'b0;
		o = 1'b0;
		unique case (op_t'(dec_s1.op))
			OP_SHLD: begin
				r = shld_res;
				c = shld_t[2*WordWidth-1];
				o = c ^ r[15];
			end
			OP_SHRD: begin
				r = shrd_res;
				c = shr_w[0];
				o = r[14] ^ r[15];
			end
			OP_ROL: begin
				r = rol_w[2*WordWidth-1:WordWidth];
				c = r[0];
				o = r[0] ^ r[15];
			end
			OP_ROR: begin
				r = ror_w[WordWidth-1:0];
				c = r[15];
				o = r[14] ^ r[15];
			end
			OP_RCL: begin
				r = rcl_y[WordWidth-1:0];
				c = rcl_y[WordWidth];
				o = c ^ r[15];
			end
			OP_RCR: begin
				r = rcr_y[WordWidth-1:0];
				c = rcr_y[WordWidth];
				o = r[14] ^ r[15];
			end
			OP_SHL: begin
				r = {shl_w[WordWidth-2:0], 1'b0};
				c = shl_w[WordWidth-1];
				o = c ^ r[15];
			end
			OP_SHR: begin
				r = shr_w[WordWidth:1];
				c = shr_w[0];
				o = r[14] ^ r[15];
			end
			OP_SAR: begin
				r = WordWidth'(sar_w >>> 1);
				c = sar_w[0];
				o = 1'b0;
			end
			default: begin
				r = dec_s1.a;
				c = 1'b0;
				o = 1'b0;
			end
		endcase
		exe_d.res = dec_s1.upd.rv ? r : dec_s1.a;
		exe_d.rv  = dec_s1.upd.rv;
		exe_d.cf  = dec_s1.upd.cov & c;
		exe_d.of  = dec_s1.upd.cov & o;
		exe_d.cov = dec_s1.upd.cov;
		exe_d.szp = dec_s1.upd.szp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dec_s1 <= dec_d;
		end
		if (en2) begin
			exe_s2 <= exe_d;
		end
		if (en3) begin
			res_s3 <= exe_s2.res;
			rv_s3  <= exe_s2.rv;
			cf_s3  <= exe_s2.cf;
			of_s3  <= exe_s2.of;
			cov_s3 <= exe_s2.cov;
			szp_s3 <= exe_s2.szp;
			sf_s3  <= exe_s2.szp & exe_s2.res[WordWidth-1];
			zf_s3  <= exe_s2.szp & (exe_s2.res == '0);
			pf_s3  <= exe_s2.szp & ~(^exe_s2.res[7:0]);
		end
	end

	assign rsp_valid            = v_s3;
	assign result               = res_s3;
	assign result_valid         = rv_s3;
	assign carry_out            = cf_s3;
	assign overflow_out         = of_s3;
	assign carry_overflow_valid = cov_s3;
	assign sign_out             = sf_s3;
	assign zero_out             = zf_s3;
	assign parity_out           = pf_s3;
	assign szp_valid            = szp_s3;

endmodule

>>> test/word_shift_rotate_unit_tb.sv
// Self-checking testbench for the word shift and rotate unit with random flow control.
`timescale 1ns / 1ps

module word_shift_rotate_unit_tb
	import wsru_pkg::*;
();

	localparam logic [OpWidth-1:0] UnusedOpFirst = OpWidth'(OP_SAR + 1);
	localparam logic [OpWidth-1:0] OpCodeLast    = '1;
	localparam int RandomItems   = 1600;
	localparam int DrainCycles   = 8;
	localparam int WatchdogLimit = 1000;

	typedef struct packed {
		logic [WordWidth-1:0] result;
		logic                 result_valid;
		logic                 carry_out;
		logic                 overflow_out;
		logic                 carry_overflow_valid;
		logic                 sign_out;
		logic                 zero_out;
		logic                 parity_out;
		logic                 szp_valid;
	} shift_outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	logic [OpWidth-1:0]    op;
	logic [WordWidth-1:0]  operand;
	logic [WordWidth-1:0]  fill_operand;
	logic [CountWidth-1:0] shift_count;
	logic                  carry_in;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [WordWidth-1:0]  result;
	logic                  result_valid;
	logic                  carry_out;
	logic                  overflow_out;
	logic                  carry_overflow_valid;
	logic                  sign_out;
	logic                  zero_out;
	logic                  parity_out;
	logic                  szp_valid;

	shift_outcome_t pending_outcomes[$];
	int             mismatch_count = 0;
	int             burst_left = 0;
	int             idle_cycles = 0;
	logic [9:0]     stall_cycle = '0;

	word_shift_rotate_unit DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.req_valid           (req_valid),
		.req_stall           (req_stall),
		.op                  (op),
		.operand             (operand),
		.fill_operand        (fill_operand),
		.shift_count         (shift_count),
		.carry_in            (carry_in),
		.rsp_valid           (rsp_valid),
		.rsp_stall           (rsp_stall),
		.result              (result),
		.result_valid        (result_valid),
		.carry_out           (carry_out),
		.overflow_out        (overflow_out),
		.carry_overflow_valid(carry_overflow_valid),
		.sign_out            (sign_out),
		.zero_out            (zero_out),
		.parity_out          (parity_out),
		.szp_valid           (szp_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic shift_outcome_t predict_shift_rotate(logic [OpWidth-1:0] opc,
			logic [WordWidth-1:0] a, logic [WordWidth-1:0] b,
			logic [CountWidth-1:0] cnt, logic cin);
		shift_outcome_t o;
		logic [31:0] a32, cin32, t, r, res, fill;
		logic [4:0]  c5, n;
		logic [3:0]  c4;
		logic        cry, ovf, rv, cov, szp;
		a32   = {16'h0000, a};
		cin32 = {31'b0, cin};
		c5    = cnt[4:0];
		c4    = cnt[3:0];
		n     = 5'(c5 % 17);
		res   = a32;
		cry   = 1'b0;
		ovf   = 1'b0;
		rv    = 1'b0;
		cov   = 1'b0;
		szp   = 1'b0;
		case (opc)
			OP_SHLD: if (c5 != 0) begin
				t = {a, b};
				r = t << c5;
				if (c5 > 16)
					r = r | (a32 << (c5 - 16));
				res = {16'h0000, r[31:16]};
				cry = t[32 - c5];
				ovf = cry ^ res[15];
				{rv, cov, szp} = 3'b111;
			end
			OP_SHRD: if (c5 != 0) begin
				t = {b, a};
				r = t >> c5;
				if (c5 > 16)
					r = r | (a32 << (32 - c5));
				res = r & 32'hffff;
				cry = a32[c5 - 1];
				ovf = res[14] ^ res[15];
				{rv, cov, szp} = 3'b111;
			end
			OP_ROL, OP_ROR: begin
				if (c4 == 0) begin
					if (cnt[4]) begin
						if (opc == OP_ROL) begin
							cry = a[0];
							ovf = a[0] ^ a[15];
						end else begin
							cry = a[15];
							ovf = a[14] ^ a[15];
						end
						cov = 1'b1;
					end
				end else begin
					if (opc == OP_ROL) begin
						res = ((a32 << c4) | (a32 >> (16 - c4))) & 32'hffff;
						cry = res[0];
						ovf = cry ^ res[15];
					end else begin
						res = ((a32 >> c4) | (a32 << (16 - c4))) & 32'hffff;
						cry = res[15];
						ovf = res[14] ^ res[15];
					end
					{rv, cov} = 2'b11;
				end
			end
			OP_RCL, OP_RCR: if (n != 0) begin
				if (opc == OP_RCL) begin
					res = ((a32 << n) | (cin32 << (n - 1)) | (a32 >> (17 - n))) & 32'hffff;
					cry = a32[16 - n];
					ovf = cry ^ res[15];
				end else begin
					res = ((a32 >> n) | (cin32 << (16 - n)) | (a32 << (17 - n))) & 32'hffff;
					cry = a32[n - 1];
					ovf = res[14] ^ res[15];
				end
				{rv, cov} = 2'b11;
			end
			OP_SHL: if (c5 != 0) begin
				if (c5 <= 16) begin
					res = (a32 << c5) & 32'hffff;
					cry = a32[16 - c5];
					ovf = cry ^ res[15];
				end else begin
					res = '0;
				end
				{rv, cov, szp} = 3'b111;
			end
			OP_SHR: if (c5 != 0) begin
				res = a32 >> c5;
				cry = a32[c5 - 1];
				ovf = res[14] ^ res[15];
				{rv, cov, szp} = 3'b111;
			end
			OP_SAR: if (c5 != 0) begin
				fill = a[15] ? 32'hffff : 32'h0;
				if (c5 < 16) begin
					res = ((a32 >> c5) | (fill << (16 - c5))) & 32'hffff;
					cry = a32[c5 - 1];
				end else begin
					res = fill;
					cry = fill[0];
				end
				{rv, cov, szp} = 3'b111;
			end
			default: ;
		endcase
		o.result               = rv ? res[15:0] : a;
		o.result_valid         = rv;
		o.carry_out            = cov & cry;
		o.overflow_out         = cov & ovf;
		o.carry_overflow_valid = cov;
		o.sign_out             = szp & res[15];
		o.zero_out             = szp & (res[15:0] == 16'h0000);
		o.parity_out           = szp & ~^res[7:0];
		o.szp_valid            = szp;
		return o;
	endfunction

	task automatic compare_field(string name, logic [WordWidth-1:0] want,
			logic [WordWidth-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic compare_flag(string name, logic want, logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Check the output item, then record the prediction for the input item.
	always @(posedge clk) begin
		shift_outcome_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual result %h",
						$time, result);
					mismatch_count++;
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("result", want.result, result);
					compare_flag("result_valid", want.result_valid, result_valid);
					compare_flag("carry_out", want.carry_out, carry_out);
					compare_flag("overflow_out", want.overflow_out, overflow_out);
					compare_flag("carry_overflow_valid", want.carry_overflow_valid,
						carry_overflow_valid);
					compare_flag("sign_out", want.sign_out, sign_out);
					compare_flag("zero_out", want.zero_out, zero_out);
					compare_flag("parity_out", want.parity_out, parity_out);
					compare_flag("szp_valid", want.szp_valid, szp_valid);
				end
			end
			if (req_valid && !req_stall)
				pending_outcomes.push_back(predict_shift_rotate(op, operand, fill_operand,
					shift_count, carry_in));
		end
	end

	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1'b1;
		case (stall_cycle[9:8])
			2'd0: rsp_stall <= 1'b0;
			2'd1: rsp_stall <= ($urandom_range(3) == 0);
			2'd2: rsp_stall <= ($urandom_range(3) != 0);
			default: rsp_stall <= stall_cycle[3];
		endcase
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("word_shift_rotate_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(logic [OpWidth-1:0] opc, logic [WordWidth-1:0] a,
			logic [WordWidth-1:0] b, logic [CountWidth-1:0] cnt, logic cin);
		int gap;
		op           <= opc;
		operand      <= a;
		fill_operand <= b;
		shift_count  <= cnt;
		carry_in     <= cin;
		req_valid    <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	function automatic logic [WordWidth-1:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			default: return WordWidth'($urandom);
		endcase
	endfunction

	function automatic logic [CountWidth-1:0] rand_count();
		case ($urandom_range(3))
			0: return CountWidth'($urandom_range(31));
			1: return CountWidth'($urandom_range(3, 1));
			2: return CountWidth'($urandom_range(15)) << 4;
			default: return CountWidth'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [OpWidth-1:0] rand_op();
		if ($urandom_range(19) == 0)
			return OpWidth'($urandom_range(OpCodeLast, UnusedOpFirst));
		return OpWidth'($urandom_range(OP_SAR));
	endfunction

	task automatic test_each_operation();
		for (int k = OP_SHLD; k <= OP_SAR; k++)
			send_item(OpWidth'(k), 16'h8001, 16'h7ffe, 8'd1, 1'b1);
	endtask

	task automatic test_count_edges();
		send_item(OP_ROL, 16'h8000, 16'h0000, 8'h10, 1'b0);
		send_item(OP_ROR, 16'h4001, 16'h0000, 8'hf0, 1'b0);
		send_item(OP_ROL, 16'hffff, 16'h0000, 8'h20, 1'b1);
		send_item(OP_RCL, 16'h8001, 16'h0000, 8'd17, 1'b1);
		send_item(OP_RCR, 16'h0001, 16'h0000, 8'd16, 1'b1);
		send_item(OP_SHLD, 16'hffff, 16'h0000, 8'd31, 1'b0);
		send_item(OP_SHLD, 16'h0000, 16'hffff, 8'd16, 1'b1);
		send_item(OP_SHRD, 16'h8001, 16'hffff, 8'd17, 1'b0);
		send_item(OP_SHL, 16'hffff, 16'h0000, 8'd16, 1'b0);
		send_item(OP_SHL, 16'hffff, 16'h0000, 8'd17, 1'b0);
		send_item(OP_SAR, 16'h8000, 16'h0000, 8'd16, 1'b0);
		send_item(OP_SAR, 16'h7fff, 16'h0000, 8'hff, 1'b0);
		send_item(OP_SHR, 16'hffff, 16'hffff, 8'h00, 1'b1);
	endtask

	task automatic test_undefined_ops();
		send_item(UnusedOpFirst, 16'hffff, 16'hffff, 8'hff, 1'b1);
		send_item(OpCodeLast, 16'h1234, 16'h0000, 8'd5, 1'b0);
	endtask

	task automatic test_random_items();
		repeat (RandomItems)
			send_item(rand_op(), rand_word(), rand_word(), rand_count(), 1'($urandom));
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		op           <= '0;
		operand      <= '0;
		fill_operand <= '0;
		shift_count  <= '0;
		carry_in     <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_operation();
		test_count_edges();
		test_undefined_ops();
		test_random_items();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("word_shift_rotate_unit test passed");
		else
			$display("word_shift_rotate_unit test failed");
		$finish;
	end

endmodule
